// ----- hw/rtl/multi_pattern_substring_matcher_unit_macros.svh -----
// Assertion helpers for the RTL of the substring matcher.
// Each macro takes a label, a clock, an active-low reset, an antecedent
// and a consequent.
`ifndef MULTI_PATTERN_SUBSTRING_MATCHER_UNIT_MACROS_SVH
`define MULTI_PATTERN_SUBSTRING_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define MPSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MPSM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/mpsm_pkg.sv -----
`timescale 1ns / 1ps

package mpsm_pkg;

	localparam int CHAR_W    = 8;
	localparam int PATTERN_W = 64;
	localparam int LEN_W     = 4;
	localparam int LENGTHS_W = 16;
	localparam int COUNT_W   = 3;
	localparam int SEEN_W    = 3;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTHS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT     = 3'd5;

endpackage

// ----- hw/rtl/mpsm_slot_cmp.sv -----
`timescale 1ns / 1ps

module mpsm_slot_cmp #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int HIST_SIZE         = 7
) (
	input  logic [mpsm_pkg::PATTERN_W-1:0]        pattern_word,
	input  logic [mpsm_pkg::LEN_W-1:0]            pattern_len,
	input  logic [mpsm_pkg::CHAR_W-1:0]           cur_byte,
	input  logic [HIST_SIZE*mpsm_pkg::CHAR_W-1:0] history,
	input  logic [mpsm_pkg::SEEN_W-1:0]           bytes_seen,
	output logic                                  hit
);

	logic [mpsm_pkg::CHAR_W-1:0] window [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES:1]  eq;
	logic [mpsm_pkg::LEN_W:0]    avail;

	// Window byte k is the byte k positions before the current one.
	always_comb begin
		window[0] = cur_byte;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			window[k] = history[(k-1)*mpsm_pkg::CHAR_W +: mpsm_pkg::CHAR_W];
		end
	end

	// One comparator group per candidate length, so every index is constant.
	always_comb begin
		for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
			eq[l] = 1'b1;
			for (int j = 0; j < l; j++) begin
				if (pattern_word[j*mpsm_pkg::CHAR_W +: mpsm_pkg::CHAR_W] != window[l-1-j]) begin
					eq[l] = 1'b0;
				end
			end
		end
	end

	assign avail = (mpsm_pkg::LEN_W+1)'(bytes_seen) + (mpsm_pkg::LEN_W+1)'(1);

	// An empty pattern always hits; a length above the window never does.
	always_comb begin
		hit = (pattern_len == '0);
		for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
			if (pattern_len == mpsm_pkg::LEN_W'(l)) begin
				hit = eq[l] && (avail >= (mpsm_pkg::LEN_W+1)'(l));
			end
		end
	end

endmodule

// ----- hw/rtl/multi_pattern_substring_matcher_unit.sv -----
`timescale 1ns / 1ps
// An item is registered in the input register when it is accepted and compared
// while it is held there; the result of a line is registered in the output
// register when its last item moves on from the input register.
// Throughput: one item per cycle. An item that ends a line waits in the input
// register only while the result of the previous line is still held.
// Reset clears the configuration registers, the line state except the history and both valid flags.

`include "multi_pattern_substring_matcher_unit_macros.svh"

module multi_pattern_substring_matcher_unit #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int PATTERN_SLOTS     = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mpsm_pkg::CHAR_W-1:0]         char_byte,
	input  logic                                has_char,
	input  logic                                end_of_line,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                line_matches,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpsm_pkg::PATTERN_W-1:0]      cfg_data
);

	localparam int HIST_DEPTH = MAX_PATTERN_BYTES - 1;
	localparam int HIST_SIZE  = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;

	// Configuration registers.
	logic [mpsm_pkg::PATTERN_W-1:0]             pattern_q [PATTERN_SLOTS];
	logic [PATTERN_SLOTS*mpsm_pkg::LEN_W-1:0]   lengths_q;
	logic [mpsm_pkg::COUNT_W-1:0]               active_q;

	// Input register.
	logic                                       valid_s1;
	logic [mpsm_pkg::CHAR_W-1:0]                char_s1;
	logic                                       has_char_s1;
	logic                                       eol_s1;

	// Line state.
	logic [HIST_SIZE*mpsm_pkg::CHAR_W-1:0]      history_q;
	logic [mpsm_pkg::SEEN_W-1:0]                seen_q;
	logic                                       found_q;

	// Output register.
	logic                                       out_valid_q;
	logic                                       line_matches_q;

	logic [PATTERN_SLOTS-1:0]                   hits;
	logic [PATTERN_SLOTS-1:0]                   slot_en;
	logic                                       found_next;
	logic                                       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < PATTERN_SLOTS; s++) begin
				pattern_q[s] <= '0;
			end
			lengths_q <= '0;
			active_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			for (int s = 0; s < PATTERN_SLOTS; s++) begin
				if (cfg_index == mpsm_pkg::CFG_IDX_W'(s)) begin
					pattern_q[s] <= cfg_data;
				end
			end
			if (cfg_index == mpsm_pkg::CFG_PATTERN_LENGTHS) begin
				lengths_q <= cfg_data[PATTERN_SLOTS*mpsm_pkg::LEN_W-1:0];
			end
			if (cfg_index == mpsm_pkg::CFG_ACTIVE_COUNT) begin
				active_q <= cfg_data[mpsm_pkg::COUNT_W-1:0];
			end
		end
	end

	// The held item moves on unless it ends a line while a result still waits.
	assign advance  = valid_s1 && (!eol_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1     <= char_byte;
			has_char_s1 <= has_char;
			eol_s1      <= end_of_line;
		end
	end

	generate
		for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_slot
			mpsm_slot_cmp #(
				.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
				.HIST_SIZE        (HIST_SIZE)
			) u_slot_cmp (
				.pattern_word(pattern_q[s]),
				.pattern_len (lengths_q[s*mpsm_pkg::LEN_W +: mpsm_pkg::LEN_W]),
				.cur_byte    (char_s1),
				.history     (history_q),
				.bytes_seen  (seen_q),
				.hit         (hits[s])
			);
			assign slot_en[s] = (active_q > mpsm_pkg::COUNT_W'(s));
		end
	endgenerate

	assign found_next = found_q || (has_char_s1 && |(hits & slot_en));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			if (eol_s1) begin
				seen_q  <= '0;
				found_q <= 1'b0;
			end else begin
				found_q <= found_next;
				if (has_char_s1 && (seen_q < mpsm_pkg::SEEN_W'(HIST_DEPTH))) begin
					seen_q <= seen_q + mpsm_pkg::SEEN_W'(1);
				end
			end
		end
	end

	// History contents beyond seen_q are never compared, so no clear is needed.
	always_ff @(posedge clk) begin
		if (advance && has_char_s1) begin
			for (int k = HIST_SIZE - 1; k > 0; k--) begin
				history_q[k*mpsm_pkg::CHAR_W +: mpsm_pkg::CHAR_W] <=
					history_q[(k-1)*mpsm_pkg::CHAR_W +: mpsm_pkg::CHAR_W];
			end
			history_q[0 +: mpsm_pkg::CHAR_W] <= char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eol_s1) begin
			line_matches_q <= found_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_matches = line_matches_q;

	`MPSM_ASSERT_NEXT(a_line_end_gives_result, clk, arst_n, advance && eol_s1, out_valid_q)
	`MPSM_ASSERT_NEXT(a_line_end_clears_state, clk, arst_n, advance && eol_s1,
		(seen_q == '0) && !found_q)
	`MPSM_ASSERT_NEXT(a_found_is_sticky, clk, arst_n, found_q && !(advance && eol_s1), found_q)
	`MPSM_ASSERT_NEXT(a_empty_line_no_match, clk, arst_n,
		advance && eol_s1 && !has_char_s1 && (seen_q == '0), !line_matches_q)

endmodule

// ----- tb/line_match_checker.sv -----
`timescale 1ns / 1ps

module line_match_checker
	import mpsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CHAR_W-1:0]    char_byte,
	input  logic                 has_char,
	input  logic                 end_of_line,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 line_matches,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PATTERN_W-1:0] cfg_data,
	output int                   failures,
	output int                   pending
);

	localparam int MAX_BYTES  = 8;
	localparam int SLOTS      = 4;
	localparam int HIST_DEPTH = MAX_BYTES - 1;

	logic [PATTERN_W-1:0] pat_word [0:SLOTS-1];
	logic [LENGTHS_W-1:0] pat_lens;
	logic [COUNT_W-1:0]   pat_count;
	logic [CHAR_W-1:0]    history [0:HIST_DEPTH-1];
	logic [SEEN_W-1:0]    seen;
	logic                 found;
	logic                 line_verdicts [$];
	int                   errs;

	task automatic report(string what, logic got, logic want);
		$display("%0t mismatch: %s, got %b want %b", $time, what, got, want);
		errs++;
	endtask

	task automatic clear_line();
		int k;
		for (k = 0; k < HIST_DEPTH; k++) begin
			history[k] = '0;
		end
		seen = '0;
		found = 1'b0;
	endtask

	// True when slot s occurs in the line ending exactly at the current byte.
	function automatic logic slot_ends_here(int s, logic [CHAR_W-1:0] cur);
		int len;
		int back;
		int j;
		logic [CHAR_W-1:0] line_byte;
		len = int'(pat_lens[4*s +: 4]);
		if (len == 0)
			return 1'b1;
		if (len > MAX_BYTES || len > int'(seen) + 1)
			return 1'b0;
		for (j = 0; j < len; j++) begin
			back = len - 1 - j;
			if (back == 0)
				line_byte = cur;
			else
				line_byte = history[back - 1];
			if (line_byte != pat_word[s][8*j +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic absorb_item(logic [CHAR_W-1:0] cur, logic has, logic eol);
		int active;
		int s;
		int k;
		active = (pat_count > SLOTS) ? SLOTS : int'(pat_count);
		if (has) begin
			for (s = 0; s < active; s++) begin
				if (slot_ends_here(s, cur))
					found = 1'b1;
			end
			for (k = HIST_DEPTH - 1; k > 0; k--) begin
				history[k] = history[k - 1];
			end
			history[0] = cur;
			if (seen < HIST_DEPTH)
				seen++;
		end
		if (eol) begin
			line_verdicts.push_back(found);
			clear_line();
		end
	endtask

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] data);
		case (idx)
			CFG_PATTERN_WORD_0: pat_word[0] = data;
			CFG_PATTERN_WORD_1: pat_word[1] = data;
			CFG_PATTERN_WORD_2: pat_word[2] = data;
			CFG_PATTERN_WORD_3: pat_word[3] = data;
			CFG_PATTERN_LENGTHS: pat_lens = data[LENGTHS_W-1:0];
			CFG_ACTIVE_COUNT: pat_count = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_result(logic got);
		logic want;
		if (line_verdicts.size() == 0) begin
			report("result with no line waiting", got, 1'bx);
		end else begin
			want = line_verdicts.pop_front();
			if (got !== want)
				report("line_matches", got, want);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pat_word[0] = '0;
			pat_word[1] = '0;
			pat_word[2] = '0;
			pat_word[3] = '0;
			pat_lens = '0;
			pat_count = '0;
			clear_line();
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				absorb_item(char_byte, has_char, end_of_line);
			if (out_valid && out_ready)
				check_result(line_matches);
		end
		failures <= errs;
		pending <= line_verdicts.size();
	end

endmodule

// ----- tb/multi_pattern_substring_matcher_unit_test.sv -----
`timescale 1ns / 1ps

module multi_pattern_substring_matcher_unit_test;
	import mpsm_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int ITEM_TARGET = 600;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] WORD_REG [0:3] = '{
		CFG_PATTERN_WORD_0, CFG_PATTERN_WORD_1, CFG_PATTERN_WORD_2, CFG_PATTERN_WORD_3
	};

	typedef logic [CHAR_W-1:0] text_t [$];

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    char_byte;
	logic                 has_char;
	logic                 end_of_line;
	logic                 out_valid;
	logic                 out_ready;
	logic                 line_matches;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PATTERN_W-1:0] cfg_data;

	int failures;
	int pending;
	int quiet;
	int items_sent;
	bit tx_calm;
	bit rx_calm;

	// Copy of the programmed patterns, used only to plant matches in lines.
	logic [PATTERN_W-1:0] words [0:3];
	logic [LENGTHS_W-1:0] lens_cfg;

	always #10 clk = ~clk;

	multi_pattern_substring_matcher_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.has_char     (has_char),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_matches (line_matches),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	line_match_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.has_char     (has_char),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_matches (line_matches),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.pending      (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: stall a random number of cycles before taking each item.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	function automatic logic [CHAR_W-1:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'h61 + 8'($urandom_range(0, 3));
		if (r == 7)
			return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(logic [CHAR_W-1:0] b, logic has, logic eol);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_byte <= b;
		has_char <= has;
		end_of_line <= eol;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		if (has || eol)
			items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] data);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_PATTERN_WORD_0: words[0] = data;
			CFG_PATTERN_WORD_1: words[1] = data;
			CFG_PATTERN_WORD_2: words[2] = data;
			CFG_PATTERN_WORD_3: words[3] = data;
			CFG_PATTERN_LENGTHS: lens_cfg = data[LENGTHS_W-1:0];
			default: ;
		endcase
	endtask

	// An empty line is a single item with no byte that ends the line. Other
	// lines may carry ignored no-byte items and may end on a no-byte item.
	task automatic send_line(input text_t text);
		int i;
		bit nochar_tail;
		if (text.size() == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			nochar_tail = ($urandom_range(0, 7) == 0);
			for (i = 0; i < text.size(); i++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				send_item(text[i], 1'b1, (i == text.size() - 1) && !nochar_tail);
			end
			if (nochar_tail)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	task automatic send_text(string s);
		text_t t;
		int i;
		for (i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		send_line(t);
	endtask

	task automatic send_run(logic [CHAR_W-1:0] b, int n);
		text_t t;
		repeat (n) t.push_back(b);
		send_line(t);
	endtask

	// Random filler from a small alphabet, often with a whole or truncated
	// copy of one of the programmed patterns planted somewhere in it.
	task automatic random_line();
		text_t t;
		int n;
		int s;
		int plen;
		int pos;
		int j;
		n = $urandom_range(0, 12);
		if ($urandom_range(0, 15) == 0)
			n = $urandom_range(13, 30);
		for (j = 0; j < n; j++) begin
			t.push_back(pick_char());
		end
		if ($urandom_range(0, 1) == 1) begin
			s = $urandom_range(0, 3);
			plen = int'(lens_cfg[4*s +: 4]);
			if (plen >= 1 && plen <= 8) begin
				if ($urandom_range(0, 3) == 0)
					plen--;
				pos = $urandom_range(0, t.size());
				for (j = 0; j < plen; j++) begin
					t.insert(pos + j, words[s][8*j +: 8]);
				end
			end
		end
		send_line(t);
	endtask

	task automatic random_setup();
		logic [PATTERN_W-1:0] w;
		logic [LENGTHS_W-1:0] lens;
		int s;
		int j;
		int r;
		for (s = 0; s < 4; s++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				w = '0;
			end else if (r == 1) begin
				w = '1;
			end else begin
				for (j = 0; j < 8; j++) begin
					w[8*j +: 8] = pick_char();
				end
			end
			write_reg(WORD_REG[s], w);
		end
		for (s = 0; s < 4; s++) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				lens[4*s +: 4] = 4'd0;
			else if (r < 4)
				lens[4*s +: 4] = 4'($urandom_range(9, 15));
			else
				lens[4*s +: 4] = 4'($urandom_range(1, 8));
		end
		r = $urandom_range(0, 11);
		if (r == 0)
			lens = 16'hFFFF;
		else if (r == 1)
			lens = 16'h8888;
		// Upper data bits are random; the block must drop them.
		w = {$urandom(), $urandom()};
		w[LENGTHS_W-1:0] = lens;
		write_reg(CFG_PATTERN_LENGTHS, w);
		r = $urandom_range(0, 9);
		w = {$urandom(), $urandom()};
		w[COUNT_W-1:0] = (r > 7) ? 3'd4 : 3'(r);
		write_reg(CFG_ACTIVE_COUNT, w);
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
				{$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	// Wait until every line result is back and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_byte <= '0;
		has_char <= 1'b0;
		end_of_line <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		words[0] = '0;
		words[1] = '0;
		words[2] = '0;
		words[3] = '0;
		lens_cfg = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration has no active slot.
		send_text("ab");
		settle();

		// A zero pattern must not match against history bytes not yet seen in the line.
		write_reg(CFG_PATTERN_WORD_0, 64'h0);
		write_reg(CFG_PATTERN_WORD_1, '1);
		write_reg(CFG_PATTERN_WORD_2, 64'h0000_0000_0063_6261);
		write_reg(CFG_PATTERN_WORD_3, 64'h0);
		write_reg(CFG_PATTERN_LENGTHS, 64'h0383);
		write_reg(CFG_ACTIVE_COUNT, 64'd3);
		write_reg(CFG_SPARE_6, '1);
		write_reg(CFG_SPARE_7, '1);
		cfg_valid <= 1'b0;
		send_run(8'h00, 2);
		send_run(8'h00, 3);
		send_run(8'hFF, 8);
		send_text("xabc");
		send_item(8'hFF, 1'b0, 1'b1);
		settle();

		// Empty pattern in slot 0, oversized lengths elsewhere, count above slots.
		write_reg(CFG_PATTERN_LENGTHS, 64'hFFF0);
		write_reg(CFG_ACTIVE_COUNT, 64'd7);
		cfg_valid <= 1'b0;
		send_item("q", 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		settle();

		write_reg(CFG_PATTERN_LENGTHS, 64'hF9FF);
		write_reg(CFG_ACTIVE_COUNT, 64'd4);
		cfg_valid <= 1'b0;
		send_text("abc");

		while (items_sent < ITEM_TARGET) begin
			settle();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			random_setup();
			repeat ($urandom_range(6, 14)) random_line();
		end
		settle();
		repeat (8) @(posedge clk);

		if (failures == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
